/* rtl/core/assert_macros.svh */
// Assertion macros used by the fill engine of the rectangle fill stream.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent at the same edge.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* rtl/core/lrfs_pkg.sv */
// Types, codes and helpers shared by the rectangle fill stream modules.
package lrfs_pkg;

   localparam int COORD_BITS     = 10;
   localparam int PIXEL_BITS     = 2 * COORD_BITS;
   localparam int COLOR_BITS     = 24;
   localparam int STEP_BITS      = 4;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [COORD_BITS-1:0] SCREEN_RESET = COORD_BITS'(320);

   localparam logic [7:0] CMD_COLUMN   = 8'h2A;
   localparam logic [7:0] CMD_ROW      = 8'h2B;
   localparam logic [7:0] CMD_WRITE    = 8'h2C;
   localparam logic [7:0] CHANNEL_MASK = 8'hFC;

   localparam logic [STEP_BITS-1:0] PIXEL_PHASE = STEP_BITS'(11);

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_FILL = 1'b1;

   localparam logic [1:0] STATUS_BYTE   = 2'd0;
   localparam logic [1:0] STATUS_BOUNDS = 2'd1;
   localparam logic [1:0] STATUS_BUSY   = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_HEIGHT = 1'b1;

   typedef struct packed {
      logic                  opcode;
      logic [COORD_BITS-1:0] x_start;
      logic [COORD_BITS-1:0] y_start;
      logic [COORD_BITS-1:0] fill_width;
      logic [COORD_BITS-1:0] fill_height;
      logic [COLOR_BITS-1:0] fill_color;
   } lrfs_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] spi_byte;
      logic       is_data;
      logic       end_of_transfer;
   } lrfs_rsp_type;

   // Engine to result register.
   typedef struct packed {
      logic         valid;
      lrfs_rsp_type data;
   } lrfs_result_type;

   function automatic logic [7:0] coord_hi(input logic [COORD_BITS-1:0] v);
      logic [15:0] wide;
      wide = 16'(v);
      return wide[15:8];
   endfunction

   function automatic logic [7:0] coord_lo(input logic [COORD_BITS-1:0] v);
      logic [15:0] wide;
      wide = 16'(v);
      return wide[7:0];
   endfunction

endpackage

/* rtl/core/lcd_rectangle_fill_stream_top.sv */
// Top level of the SPI LCD rectangle fill byte stream.
// Takes fill requests and ticks, one item per clock when the result side keeps up;
// an item is held in the input register until the engine takes it, and its result (if
// any) is loaded into the result register as the engine takes it; rsp_valid and
// rsp_data come from the result register. While a result is stalled the input stalls
// too, also for items that yield nothing. A tick while a fill runs yields the next SPI
// byte: column window, row window, write command, then three color bytes per pixel,
// with data/command and chip-select-release flags. A request while busy, with a zero
// size or out of the configured screen yields a reject status; an accepted request
// and an idle tick yield nothing. Screen size registers are always ready and must be
// written only while the block is idle.
module lcd_rectangle_fill_stream_top
   import lrfs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  lrfs_req_type              req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output lrfs_rsp_type              rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]     csr_wdata
);

   logic            out_free;
   logic            fire;
   lrfs_req_type    item;
   lrfs_result_type result;

   lrfs_input_stage u_input (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .out_free  (out_free),
      .fire      (fire),
      .item      (item)
   );

   lrfs_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fire      (fire),
      .item      (item),
      .result    (result)
   );

   lrfs_output_stage u_output (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/core/lrfs_input_stage.sv */
// Input register: holds one request item until the engine can take it.
module lrfs_input_stage
   import lrfs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  lrfs_req_type req_data,
   input  logic         out_free,
   output logic         fire,
   output lrfs_req_type item
);

   logic         valid_ff;
   logic         valid_in;
   lrfs_req_type data_ff;
   logic         take;

   assign fire      = valid_ff && out_free;
   assign req_stall = valid_ff && !out_free;
   assign take      = req_valid && !req_stall;
   assign item      = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= req_data;
      end
   end

endmodule

/* rtl/core/lrfs_engine.sv */
// Fill engine: screen registers, window and pixel counters, byte selection.
`include "assert_macros.svh"

module lrfs_engine
   import lrfs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]     csr_wdata,
   input  logic                      fire,
   input  lrfs_req_type              item,
   output lrfs_result_type           result
);

   localparam logic [STEP_BITS-1:0] HDR_COL_CMD  = STEP_BITS'(0);
   localparam logic [STEP_BITS-1:0] HDR_COL_F_HI = STEP_BITS'(1);
   localparam logic [STEP_BITS-1:0] HDR_COL_F_LO = STEP_BITS'(2);
   localparam logic [STEP_BITS-1:0] HDR_COL_L_HI = STEP_BITS'(3);
   localparam logic [STEP_BITS-1:0] HDR_COL_L_LO = STEP_BITS'(4);
   localparam logic [STEP_BITS-1:0] HDR_ROW_CMD  = STEP_BITS'(5);
   localparam logic [STEP_BITS-1:0] HDR_ROW_F_HI = STEP_BITS'(6);
   localparam logic [STEP_BITS-1:0] HDR_ROW_F_LO = STEP_BITS'(7);
   localparam logic [STEP_BITS-1:0] HDR_ROW_L_HI = STEP_BITS'(8);
   localparam logic [STEP_BITS-1:0] HDR_ROW_L_LO = STEP_BITS'(9);
   localparam logic [STEP_BITS-1:0] HDR_WRITE    = STEP_BITS'(10);

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   logic [COORD_BITS-1:0] screen_width_ff, screen_width_in;
   logic [COORD_BITS-1:0] screen_height_ff, screen_height_in;

   logic                  busy_ff, busy_in;
   logic [STEP_BITS-1:0]  header_step_ff, header_step_in;
   logic [COORD_BITS-1:0] col_first_ff, col_first_in;
   logic [COORD_BITS-1:0] col_last_ff, col_last_in;
   logic [COORD_BITS-1:0] row_first_ff, row_first_in;
   logic [COORD_BITS-1:0] row_last_ff, row_last_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;
   logic [PIXEL_BITS-1:0] pixels_left_ff, pixels_left_in;
   logic [1:0]            channel_ff, channel_in;

   logic [COORD_BITS:0]   col_end;
   logic [COORD_BITS:0]   row_end;
   logic [COORD_BITS:0]   col_last_wide;
   logic [COORD_BITS:0]   row_last_wide;
   logic                  in_bounds;
   logic [PIXEL_BITS-1:0] pixels_remaining;

   assign csr_ready = 1'b1;

   always_comb begin
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  screen_width_in  = csr_wdata;
            CSR_SCREEN_HEIGHT: screen_height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign col_end       = {1'b0, item.x_start} + {1'b0, item.fill_width};
   assign row_end       = {1'b0, item.y_start} + {1'b0, item.fill_height};
   assign col_last_wide = col_end - (COORD_BITS+1)'(1);
   assign row_last_wide = row_end - (COORD_BITS+1)'(1);
   assign in_bounds     = (item.fill_width != '0) && (item.fill_height != '0)
                          && (col_end <= {1'b0, screen_width_ff})
                          && (row_end <= {1'b0, screen_height_ff});
   assign pixels_remaining = pixels_left_ff - PIXEL_BITS'(1);

   always_comb begin
      busy_in        = busy_ff;
      header_step_in = header_step_ff;
      col_first_in   = col_first_ff;
      col_last_in    = col_last_ff;
      row_first_in   = row_first_ff;
      row_last_in    = row_last_ff;
      color_in       = color_ff;
      pixels_left_in = pixels_left_ff;
      channel_in     = channel_ff;
      result         = '0;

      if (fire) begin
         if (item.opcode == OP_FILL) begin
            if (busy_ff) begin
               result.valid       = 1'b1;
               result.data.status = STATUS_BUSY;
            end else if (!in_bounds) begin
               result.valid       = 1'b1;
               result.data.status = STATUS_BOUNDS;
            end else begin
               busy_in        = 1'b1;
               header_step_in = HDR_COL_CMD;
               col_first_in   = item.x_start;
               col_last_in    = col_last_wide[COORD_BITS-1:0];
               row_first_in   = item.y_start;
               row_last_in    = row_last_wide[COORD_BITS-1:0];
               color_in       = item.fill_color & {3{CHANNEL_MASK}};
               pixels_left_in = item.fill_width * item.fill_height;
               channel_in     = CH_RED;
            end
         end else if (busy_ff) begin
            result.valid       = 1'b1;
            result.data.status = STATUS_BYTE;
            result.data.is_data = 1'b1;
            if (header_step_ff < PIXEL_PHASE) begin
               header_step_in = header_step_ff + STEP_BITS'(1);
               unique case (header_step_ff)
                  HDR_COL_CMD: begin
                     result.data.spi_byte = CMD_COLUMN;
                     result.data.is_data  = 1'b0;
                  end
                  HDR_COL_F_HI: result.data.spi_byte = coord_hi(col_first_ff);
                  HDR_COL_F_LO: result.data.spi_byte = coord_lo(col_first_ff);
                  HDR_COL_L_HI: result.data.spi_byte = coord_hi(col_last_ff);
                  HDR_COL_L_LO: begin
                     result.data.spi_byte        = coord_lo(col_last_ff);
                     result.data.end_of_transfer = 1'b1;
                  end
                  HDR_ROW_CMD: begin
                     result.data.spi_byte = CMD_ROW;
                     result.data.is_data  = 1'b0;
                  end
                  HDR_ROW_F_HI: result.data.spi_byte = coord_hi(row_first_ff);
                  HDR_ROW_F_LO: result.data.spi_byte = coord_lo(row_first_ff);
                  HDR_ROW_L_HI: result.data.spi_byte = coord_hi(row_last_ff);
                  HDR_ROW_L_LO: begin
                     result.data.spi_byte        = coord_lo(row_last_ff);
                     result.data.end_of_transfer = 1'b1;
                  end
                  HDR_WRITE: begin
                     result.data.spi_byte        = CMD_WRITE;
                     result.data.is_data         = 1'b0;
                     result.data.end_of_transfer = 1'b1;
                  end
                  default: ;
               endcase
            end else begin
               case (channel_ff)
                  CH_RED:   result.data.spi_byte = color_ff[23:16];
                  CH_GREEN: result.data.spi_byte = color_ff[15:8];
                  default:  result.data.spi_byte = color_ff[7:0];
               endcase
               if (channel_ff >= CH_BLUE) begin
                  channel_in = CH_RED;
                  // pixel count never sits at zero in the pixel phase
                  pixels_left_in = pixels_remaining;
                  if (pixels_remaining == '0) begin
                     result.data.end_of_transfer = 1'b1;
                     busy_in        = 1'b0;
                     header_step_in = HDR_COL_CMD;
                  end
               end else begin
                  channel_in = channel_ff + 2'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= SCREEN_RESET;
         screen_height_ff <= SCREEN_RESET;
         busy_ff          <= 1'b0;
         header_step_ff   <= '0;
         col_first_ff     <= '0;
         col_last_ff      <= '0;
         row_first_ff     <= '0;
         row_last_ff      <= '0;
         color_ff         <= '0;
         pixels_left_ff   <= '0;
         channel_ff       <= '0;
      end else begin
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
         busy_ff          <= busy_in;
         header_step_ff   <= header_step_in;
         col_first_ff     <= col_first_in;
         col_last_ff      <= col_last_in;
         row_first_ff     <= row_first_in;
         row_last_ff      <= row_last_in;
         color_ff         <= color_in;
         pixels_left_ff   <= pixels_left_in;
         channel_ff       <= channel_in;
      end
   end

   `ASSERT_ALWAYS(a_step_range, clock, reset, header_step_ff <= PIXEL_PHASE, "header step past pixel phase")
   `ASSERT_IMPLY(a_idle_step, clock, reset, !busy_ff, header_step_ff == HDR_COL_CMD, "idle with header step set")
   `ASSERT_ALWAYS(a_channel_range, clock, reset, channel_ff != 2'd3, "channel index out of range")
   `ASSERT_IMPLY(a_pixels_nonzero, clock, reset, busy_ff && header_step_ff == PIXEL_PHASE, pixels_left_ff != '0, "pixel phase with no pixels left")
   `ASSERT_IMPLY(a_reject_zero, clock, reset, result.valid && result.data.status != STATUS_BYTE, result.data.spi_byte == '0 && !result.data.end_of_transfer, "reject carries stream data")

endmodule

/* rtl/core/lrfs_output_stage.sv */
// Result register: holds one result item until the consumer takes it.
module lrfs_output_stage
   import lrfs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  lrfs_result_type result,
   output logic            out_free,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output lrfs_rsp_type    rsp_data
);

   logic         valid_ff;
   logic         valid_in;
   lrfs_rsp_type data_ff;
   logic         load;

   assign out_free  = !valid_ff || !rsp_stall;
   assign load      = fire && result.valid;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (out_free) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result.data;
      end
   end

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the SPI LCD rectangle fill byte stream.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import lrfs_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 6;
   localparam int RANDOM_ITEMS   = 1200;
   localparam int RANDOM_PHASES  = 8;
   localparam int REPORT_LIMIT   = 40;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   lrfs_req_type              req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   lrfs_rsp_type              rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [COORD_BITS-1:0]     csr_wdata = '0;

   lcd_rectangle_fill_stream_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predicted panel state, mirrors the block after reset.
   logic [COORD_BITS-1:0] scr_w       = SCREEN_RESET;
   logic [COORD_BITS-1:0] scr_h       = SCREEN_RESET;
   logic                  fill_busy   = 1'b0;
   logic [STEP_BITS-1:0]  hdr_step    = '0;
   logic [COORD_BITS-1:0] col_first   = '0;
   logic [COORD_BITS-1:0] col_last    = '0;
   logic [COORD_BITS-1:0] row_first   = '0;
   logic [COORD_BITS-1:0] row_last    = '0;
   logic [COLOR_BITS-1:0] fill_rgb    = '0;
   logic [PIXEL_BITS-1:0] pixels_left = '0;
   logic [1:0]            rgb_index   = '0;

   lrfs_rsp_type lcd_out_expected[$];
   int           mismatch_count = 0;
   int           quiet_cycles   = 0;
   int unsigned  send_idle_pct  = 0;
   int unsigned  stall_pct      = 0;

   initial begin
      forever #1ns clock = ~clock;
   end

   // Returns 1 when the item yields a result; advances the predicted state.
   function automatic bit predict_lcd_out(input lrfs_req_type item, output lrfs_rsp_type rsp);
      int unsigned right, bottom;
      rsp = '0;
      if (item.opcode == OP_FILL) begin
         right  = int'(item.x_start) + int'(item.fill_width);
         bottom = int'(item.y_start) + int'(item.fill_height);
         if (fill_busy) begin
            rsp.status = STATUS_BUSY;
            return 1'b1;
         end
         if (item.fill_width == '0 || item.fill_height == '0 ||
             right > int'(scr_w) || bottom > int'(scr_h)) begin
            rsp.status = STATUS_BOUNDS;
            return 1'b1;
         end
         fill_busy   = 1'b1;
         hdr_step    = '0;
         col_first   = item.x_start;
         col_last    = COORD_BITS'(right - 1);
         row_first   = item.y_start;
         row_last    = COORD_BITS'(bottom - 1);
         fill_rgb    = item.fill_color & {CHANNEL_MASK, CHANNEL_MASK, CHANNEL_MASK};
         pixels_left = PIXEL_BITS'(int'(item.fill_width) * int'(item.fill_height));
         rgb_index   = '0;
         return 1'b0;
      end
      if (!fill_busy) return 1'b0;
      rsp.status  = STATUS_BYTE;
      rsp.is_data = 1'b1;
      if (hdr_step < PIXEL_PHASE) begin
         case (hdr_step)
            4'd0: begin
               rsp.spi_byte = CMD_COLUMN;
               rsp.is_data  = 1'b0;
            end
            4'd1: rsp.spi_byte = 8'(col_first >> 8);
            4'd2: rsp.spi_byte = col_first[7:0];
            4'd3: rsp.spi_byte = 8'(col_last >> 8);
            4'd4: begin
               rsp.spi_byte        = col_last[7:0];
               rsp.end_of_transfer = 1'b1;
            end
            4'd5: begin
               rsp.spi_byte = CMD_ROW;
               rsp.is_data  = 1'b0;
            end
            4'd6: rsp.spi_byte = 8'(row_first >> 8);
            4'd7: rsp.spi_byte = row_first[7:0];
            4'd8: rsp.spi_byte = 8'(row_last >> 8);
            4'd9: begin
               rsp.spi_byte        = row_last[7:0];
               rsp.end_of_transfer = 1'b1;
            end
            default: begin
               rsp.spi_byte        = CMD_WRITE;
               rsp.is_data         = 1'b0;
               rsp.end_of_transfer = 1'b1;
            end
         endcase
         hdr_step = hdr_step + 1'b1;
         return 1'b1;
      end
      // pixel phase: R, G, B per pixel
      rsp.spi_byte = 8'(fill_rgb >> (16 - 8 * int'(rgb_index)));
      if (rgb_index >= 2'd2) begin
         rgb_index = '0;
         if (pixels_left != '0) pixels_left = pixels_left - 1'b1;
         if (pixels_left == '0) begin
            rsp.end_of_transfer = 1'b1;
            fill_busy           = 1'b0;
            hdr_step            = '0;
         end
      end else begin
         rgb_index = rgb_index + 1'b1;
      end
      return 1'b1;
   endfunction

   function automatic lrfs_req_type fill_item(input int unsigned x, y, w, h, color);
      lrfs_req_type item;
      item.opcode      = OP_FILL;
      item.x_start     = COORD_BITS'(x);
      item.y_start     = COORD_BITS'(y);
      item.fill_width  = COORD_BITS'(w);
      item.fill_height = COORD_BITS'(h);
      item.fill_color  = COLOR_BITS'(color);
      return item;
   endfunction

   // Tick with random content in the unused fields.
   function automatic lrfs_req_type tick_item();
      logic [95:0]  raw;
      lrfs_req_type item;
      raw         = {$urandom(), $urandom(), $urandom()};
      item        = raw[$bits(lrfs_req_type)-1:0];
      item.opcode = OP_TICK;
      return item;
   endfunction

   // Mostly small rectangles so fills stay short.
   function automatic lrfs_req_type random_fill_in_bounds();
      int unsigned w_cap, h_cap, w, h;
      w_cap = ($urandom_range(3) == 0) ? 12 : 3;
      if (w_cap > int'(scr_w)) w_cap = scr_w;
      w     = $urandom_range(1, w_cap);
      h_cap = (w > 3) ? 2 : (($urandom_range(3) == 0) ? 8 : 3);
      if (h_cap > int'(scr_h)) h_cap = scr_h;
      h     = $urandom_range(1, h_cap);
      return fill_item($urandom_range(0, int'(scr_w) - w), $urandom_range(0, int'(scr_h) - h),
                       w, h, $urandom());
   endfunction

   function automatic lrfs_req_type random_fill_rejected();
      lrfs_req_type item;
      case ($urandom_range(3))
         0, 1: begin
            // random fields, start pushed to or past the right or bottom edge
            item        = tick_item();
            item.opcode = OP_FILL;
            if ($urandom_range(1)) item.x_start = item.x_start | scr_w;
            else item.y_start = item.y_start | scr_h;
         end
         2: begin
            item = random_fill_in_bounds();
            if ($urandom_range(1)) item.fill_width = '0;
            else item.fill_height = '0;
         end
         default: begin
            // one past the right or bottom edge
            item = random_fill_in_bounds();
            if ($urandom_range(1)) item.x_start = COORD_BITS'(scr_w - item.fill_width + 1'b1);
            else item.y_start = COORD_BITS'(scr_h - item.fill_height + 1'b1);
         end
      endcase
      return item;
   endfunction

   // Entered at a falling edge; leaves valid high for a back-to-back transfer.
   task automatic send_item(input lrfs_req_type item);
      int unsigned  gap;
      lrfs_rsp_type rsp;
      gap = 0;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct && gap < 20) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      if (predict_lcd_out(item, rsp)) lcd_out_expected.push_back(rsp);
      @(negedge clock);
   endtask

   task automatic drain_lcd_out();
      req_valid <= 1'b0;
      while (lcd_out_expected.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic finish_fill();
      while (fill_busy) send_item(tick_item());
   endtask

   task automatic write_screen_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                                   input logic [COORD_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_SCREEN_WIDTH) scr_w = value;
      else scr_h = value;
      @(negedge clock);
   endtask

   task automatic set_screen(input int unsigned cols, rows);
      finish_fill();
      drain_lcd_out();
      write_screen_reg(CSR_SCREEN_WIDTH, COORD_BITS'(cols));
      write_screen_reg(CSR_SCREEN_HEIGHT, COORD_BITS'(rows));
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_screen();
      send_item(tick_item());
      send_item(fill_item(319, 319, 1, 1, 24'hFFFFFF));
      finish_fill();
      send_item(fill_item(319, 0, 2, 1, $urandom()));
      send_item(fill_item(0, 319, 1, 2, $urandom()));
      send_item(fill_item(300, 0, 20, 1, $urandom()));
      finish_fill();
   endtask

   task automatic test_rejects();
      send_item(fill_item(5, 5, 0, 3, $urandom()));
      send_item(fill_item(5, 5, 3, 0, $urandom()));
      send_item(fill_item(1023, 1023, 1023, 1023, 24'hFFFFFF));
      set_screen(0, 320);
      send_item(fill_item(0, 0, 1, 1, $urandom()));
      set_screen(320, 0);
      send_item(fill_item(0, 0, 1, 1, $urandom()));
      set_screen(1, 1);
      send_item(fill_item(0, 0, 1, 1, 24'h030303));
      finish_fill();
      send_item(fill_item(1, 0, 1, 1, $urandom()));
   endtask

   task automatic test_window_bytes();
      set_screen(1023, 1023);
      // window bounds straddle the byte boundary
      send_item(fill_item(255, 511, 2, 2, 24'hA5C37E));
      finish_fill();
      send_item(fill_item(1022, 1022, 1, 1, $urandom()));
      finish_fill();
   endtask

   task automatic test_busy_reject();
      send_item(fill_item(10, 20, 3, 2, $urandom()));
      send_item(fill_item(0, 0, 1, 1, $urandom()));
      repeat (3) send_item(tick_item());
      send_item(fill_item(0, 0, 1, 1, $urandom()));
      repeat (12) send_item(tick_item());
      send_item(random_fill_rejected());
      finish_fill();
      send_item(fill_item(0, 0, 1, 1, $urandom()));
      finish_fill();
   endtask

   task automatic test_full_span();
      set_screen(48, 40);
      send_item(fill_item(0, 39, 48, 1, $urandom()));
      finish_fill();
      send_item(fill_item(47, 0, 1, 40, $urandom()));
      finish_fill();
   endtask

   task automatic test_random_traffic();
      int          phase, sent;
      int unsigned cols, rows, pick;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin cols = 320;  rows = 320;  end
            1: begin cols = 1;    rows = 1;    end
            2: begin cols = 1023; rows = 1023; end
            3: begin cols = 1;    rows = 1023; end
            4: begin cols = 1023; rows = 1;    end
            default: begin
               cols = $urandom_range(1, 1023);
               rows = $urandom_range(1, 1023);
            end
         endcase
         set_screen(cols, rows);
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 55; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 55; end
            default: begin send_idle_pct = 7; stall_pct = 7; end
         endcase
         sent = 0;
         while (sent < RANDOM_ITEMS / RANDOM_PHASES) begin
            pick = $urandom_range(19);
            if (fill_busy) begin
               if (pick == 0) send_item(random_fill_rejected());
               else if (pick == 1) send_item(random_fill_in_bounds());
               else send_item(tick_item());
               sent++;
            end else if (pick < 14) begin
               send_item(random_fill_in_bounds());
               sent++;
            end else if (pick < 17) begin
               send_item(random_fill_rejected());
               sent++;
            end else begin
               send_item(tick_item());
            end
            if ($urandom_range(149) == 0) drain_lcd_out();
         end
      end
      finish_fill();
   endtask

   always @(negedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   task automatic compare_field(input string field, input logic [7:0] want, got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t tb_top: %s mismatch, expected %0h, actual %0h",
                     $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      lrfs_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (lcd_out_expected.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t tb_top: unexpected transfer, expected none, actual %h",
                        $time, rsp_data);
         end else begin
            want = lcd_out_expected.pop_front();
            compare_field("status", 8'(want.status), 8'(rsp_data.status));
            compare_field("spi_byte", want.spi_byte, rsp_data.spi_byte);
            compare_field("is_data", 8'(want.is_data), 8'(rsp_data.is_data));
            compare_field("end_of_transfer", 8'(want.end_of_transfer),
                          8'(rsp_data.end_of_transfer));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t tb_top: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_screen();
      test_rejects();
      test_window_bytes();
      test_busy_reject();
      test_full_span();
      test_random_traffic();
      drain_lcd_out();
      if (mismatch_count == 0 && lcd_out_expected.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/lrfs_pkg.sv
rtl/core/lrfs_input_stage.sv
rtl/core/lrfs_engine.sv
rtl/core/lrfs_output_stage.sv
rtl/core/lcd_rectangle_fill_stream_top.sv
tb/tb_top.sv
